[rtl/flc_pkg.sv]
package flc_pkg;

    // ethernet and ip codes
    localparam logic [15:0] ETH_IPV4  = 16'h0800;
    localparam logic [7:0]  PROTO_TCP = 8'd6;
    localparam logic [7:0]  PROTO_UDP = 8'd17;

    // result status codes
    localparam logic [2:0] ST_NOT_IP   = 3'd0;
    localparam logic [2:0] ST_IP_OTHER = 3'd1;
    localparam logic [2:0] ST_UPDATED  = 3'd2;
    localparam logic [2:0] ST_INSERTED = 3'd3;
    localparam logic [2:0] ST_DROPPED  = 3'd4;
    localparam logic [2:0] ST_UDP_EXP  = 3'd5;

    // counter limits and register reset
    localparam logic [47:0] BYTES_MAX       = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] PKTS_MAX        = 32'hFFFF_FFFF;
    localparam logic [6:0]  MAX_FLOWS_RESET = 7'd50;

    // one packet header request
    typedef struct packed {
        logic [15:0] eth_type;
        logic [7:0]  ip_protocol;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [15:0] frame_length;
        logic [31:0] ts_seconds;
        logic [19:0] ts_microseconds;
    } flc_in_t;

    // one result
    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  entry_index;
        logic [47:0] total_bytes;
        logic [31:0] total_packets;
        logic [31:0] start_seconds;
        logic [19:0] start_microseconds;
    } flc_out_t;

    // flow key as held in the key memory
    typedef struct packed {
        logic [63:0] addrs;
        logic [31:0] ports;
    } flc_key_t;

    // flow counters as held in the counter memory, times are seconds:micros
    typedef struct packed {
        logic [47:0] bytes;
        logic [31:0] packets;
        logic [51:0] start_time;
        logic [51:0] last_time;
    } flc_ctr_t;

endpackage

[rtl/flc_ram.sv]
module flc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/flow_cache_update.sv]
// channel | direction | ports                     | payload
// s_      | in        | s_valid, s_ready, s_data  | flc_pkg::flc_in_t, one packet header
// m_      | out       | m_valid, m_ready, m_data  | flc_pkg::flc_out_t, one result
// cfg_    | in        | cfg_wr_en, cfg_wr_data    | max_flows, written without wait
//
// non-tcp packets go straight from idle to emit; a tcp packet on an empty table misses with no key read.
// otherwise a tcp packet walks the key memory one entry a cycle over the active entries,
// a rate set by the single key memory read port: a miss ends the scan after the last active entry,
// a hit reads the counter memory and writes back the update in S_UPD before emit.
// reset (aresetn low at a clock edge) empties the table at once; no clearing pass.
// a new request is taken while an earlier result still waits on m_ready.
module flow_cache_update #(
    parameter int FLOW_ENTRIES = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  flc_pkg::flc_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output flc_pkg::flc_out_t m_data,
    input  logic              cfg_wr_en,
    input  logic [6:0]        cfg_wr_data
);

    localparam int IW = $clog2(FLOW_ENTRIES);
    localparam int CW = $clog2(FLOW_ENTRIES + 1);
    localparam int LW = (CW > 7) ? CW : 7;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPD,
        S_EMIT
    } state_t;

    state_t            state_reg;
    flc_pkg::flc_in_t  in_reg;
    flc_pkg::flc_out_t res_reg;
    flc_pkg::flc_out_t m_data_reg;
    logic              m_valid_reg;
    logic [6:0]        max_flows_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     issue_reg;
    logic              pend_reg;
    logic [IW-1:0]     pend_idx_reg;
    logic [IW-1:0]     hit_idx_reg;

    flc_pkg::flc_key_t cur_key;
    flc_pkg::flc_key_t key_rdata;
    flc_pkg::flc_ctr_t ctr_rdata;
    flc_pkg::flc_ctr_t ctr_wdata;
    logic [51:0]       now;
    logic              key_re;
    logic              hit;
    logic              miss;
    logic              full;
    logic              insert;
    logic              ctr_we;
    logic [IW-1:0]     ctr_waddr;
    logic [48:0]       byte_sum;
    logic [47:0]       upd_bytes;
    logic [31:0]       upd_packets;

    // key and time of the request in work
    assign cur_key.addrs = {in_reg.src_addr, in_reg.dst_addr};
    assign cur_key.ports = {in_reg.src_port, in_reg.dst_port};
    assign now           = {in_reg.ts_seconds, in_reg.ts_microseconds};

    // scan: one key read issued a cycle, compare in the cycle after the read
    assign key_re = (state_reg == S_SCAN) && (issue_reg < count_reg);
    assign hit    = (state_reg == S_SCAN) && pend_reg && (key_rdata == cur_key);
    assign miss   = (state_reg == S_SCAN) && !pend_reg && !(issue_reg < count_reg);

    // table limit, values above the table size act as the table size
    assign full   = (LW'(count_reg) >= LW'(max_flows_reg))
                    || (count_reg == CW'(FLOW_ENTRIES));
    assign insert = miss && !full;

    // saturating counter update on a hit
    assign byte_sum    = {1'b0, ctr_rdata.bytes} + {33'b0, in_reg.frame_length};
    assign upd_bytes   = byte_sum[48] ? flc_pkg::BYTES_MAX : byte_sum[47:0];
    assign upd_packets = (ctr_rdata.packets == flc_pkg::PKTS_MAX)
                         ? ctr_rdata.packets : ctr_rdata.packets + 32'd1;

    // counter memory write: new entry or write back of a hit
    always_comb begin
        if (insert) begin
            ctr_wdata.bytes      = {32'b0, in_reg.frame_length};
            ctr_wdata.packets    = 32'd1;
            ctr_wdata.start_time = now;
            ctr_wdata.last_time  = now;
            ctr_waddr            = count_reg[IW-1:0];
        end else begin
            ctr_wdata.bytes      = upd_bytes;
            ctr_wdata.packets    = upd_packets;
            ctr_wdata.start_time = ctr_rdata.start_time;
            ctr_wdata.last_time  = now;
            ctr_waddr            = hit_idx_reg;
        end
    end
    assign ctr_we = insert || (state_reg == S_UPD);

    flc_ram #(
        .WIDTH ($bits(flc_pkg::flc_key_t)),
        .DEPTH (FLOW_ENTRIES)
    ) u_key_ram (
        .aclk    (aclk),
        .wr_en   (insert),
        .wr_addr (count_reg[IW-1:0]),
        .wr_data (cur_key),
        .rd_en   (key_re),
        .rd_addr (issue_reg[IW-1:0]),
        .rd_data (key_rdata)
    );

    flc_ram #(
        .WIDTH ($bits(flc_pkg::flc_ctr_t)),
        .DEPTH (FLOW_ENTRIES)
    ) u_ctr_ram (
        .aclk    (aclk),
        .wr_en   (ctr_we),
        .wr_addr (ctr_waddr),
        .wr_data (ctr_wdata),
        .rd_en   (hit),
        .rd_addr (pend_idx_reg),
        .rd_data (ctr_rdata)
    );

    // control state, result and output registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            m_valid_reg   <= 1'b0;
            max_flows_reg <= flc_pkg::MAX_FLOWS_RESET;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                max_flows_reg <= cfg_wr_data;
            end
            // result taken with nothing new to load
            if (m_valid_reg && m_ready && (state_reg != S_EMIT)) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        in_reg    <= s_data;
                        issue_reg <= '0;
                        pend_reg  <= 1'b0;
                        if (s_data.eth_type != flc_pkg::ETH_IPV4) begin
                            res_reg   <= '{status: flc_pkg::ST_NOT_IP, default: '0};
                            state_reg <= S_EMIT;
                        end else if (s_data.ip_protocol == flc_pkg::PROTO_UDP) begin
                            res_reg   <= '{status:             flc_pkg::ST_UDP_EXP,
                                           entry_index:        6'd0,
                                           total_bytes:        {32'b0, s_data.frame_length},
                                           total_packets:      32'd1,
                                           start_seconds:      s_data.ts_seconds,
                                           start_microseconds: s_data.ts_microseconds};
                            state_reg <= S_EMIT;
                        end else if (s_data.ip_protocol == flc_pkg::PROTO_TCP) begin
                            res_reg   <= '0;
                            state_reg <= S_SCAN;
                        end else begin
                            res_reg   <= '{status: flc_pkg::ST_IP_OTHER, default: '0};
                            state_reg <= S_EMIT;
                        end
                    end
                end
                S_SCAN: begin
                    if (hit) begin
                        hit_idx_reg <= pend_idx_reg;
                        state_reg   <= S_UPD;
                    end else if (miss) begin
                        if (full) begin
                            res_reg.status <= flc_pkg::ST_DROPPED;
                        end else begin
                            res_reg.status             <= flc_pkg::ST_INSERTED;
                            res_reg.entry_index        <= 6'(count_reg);
                            res_reg.total_bytes        <= {32'b0, in_reg.frame_length};
                            res_reg.total_packets      <= 32'd1;
                            res_reg.start_seconds      <= in_reg.ts_seconds;
                            res_reg.start_microseconds <= in_reg.ts_microseconds;
                            count_reg                  <= count_reg + CW'(1);
                        end
                        state_reg <= S_EMIT;
                    end else if (key_re) begin
                        issue_reg    <= issue_reg + CW'(1);
                        pend_reg     <= 1'b1;
                        pend_idx_reg <= issue_reg[IW-1:0];
                    end else begin
                        pend_reg <= 1'b0;
                    end
                end
                S_UPD: begin
                    res_reg.status             <= flc_pkg::ST_UPDATED;
                    res_reg.entry_index        <= 6'(hit_idx_reg);
                    res_reg.total_bytes        <= upd_bytes;
                    res_reg.total_packets      <= upd_packets;
                    res_reg.start_seconds      <= ctr_rdata.start_time[51:20];
                    res_reg.start_microseconds <= ctr_rdata.start_time[19:0];
                    state_reg                  <= S_EMIT;
                end
                S_EMIT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg  <= res_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[rtl/flc_checker.sv]
module flc_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input flc_pkg::flc_out_t m_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // reset empties the output
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // untracked and dropped packets carry only a status
    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == flc_pkg::ST_NOT_IP
                    || m_data.status == flc_pkg::ST_IP_OTHER
                    || m_data.status == flc_pkg::ST_DROPPED)
        |-> m_data.entry_index == 6'd0 && m_data.total_bytes == 48'd0
            && m_data.total_packets == 32'd0 && m_data.start_seconds == 32'd0
            && m_data.start_microseconds == 20'd0)
        else $error("nonzero fields on status-only result");

    // new flows and udp exports are single packets
    a_one_packet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == flc_pkg::ST_INSERTED
                    || m_data.status == flc_pkg::ST_UDP_EXP)
        |-> m_data.total_packets == 32'd1)
        else $error("new flow without a single packet");

    // udp exports touch no slot
    a_udp_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == flc_pkg::ST_UDP_EXP |-> m_data.entry_index == 6'd0)
        else $error("udp export with a slot index");

endmodule

bind flow_cache_update flc_checker u_flc_checker (.*);
